@@ design/serial_port_status_register_block_core_assert.svh @@
// Assertion macros for the serial port status register block.
`ifndef SERIAL_PORT_STATUS_REGISTER_BLOCK_CORE_ASSERT_SVH
`define SERIAL_PORT_STATUS_REGISTER_BLOCK_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPSRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spsrb assertion failed");
`define SPSRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spsrb assertion failed");
`else
`define SPSRB_ASSERT_NOW(label, clk, rst, ante, cons)
`define SPSRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/spsrb_pkg.sv @@
// Types and constants of the serial port status register block.
package spsrb_pkg;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_LATCH  = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_WRITE  = 3'd3;
   localparam logic [2:0] OP_LEVEL  = 3'd4;

   localparam logic [7:0] ADDR_SERIAL = 8'h50;
   localparam logic [7:0] ADDR_STATUS = 8'h51;
   localparam logic [7:0] ADDR_PORT   = 8'h70;

   localparam logic [7:0] MASK_NO_OVERRUN = 8'hFC;
   localparam logic [7:0] BITS_OVERRUN    = 8'h03;
   localparam logic [7:0] MASK_NO_DONE    = 8'hF3;
   localparam logic [7:0] BITS_DONE       = 8'h0C;
   localparam logic [7:0] BIT_TX_BUSY     = 8'h10;
   localparam logic [7:0] BIT_RX_READY    = 8'h20;
   localparam logic [7:0] BIT_MSB         = 8'h80;

   localparam logic [3:0] RX_IDLE  = 4'd0;
   localparam logic [3:0] RX_START = 4'd1;
   localparam logic [3:0] RX_FIRST = 4'd2;
   localparam logic [3:0] RX_BITS  = 4'd9;
   localparam logic [3:0] RX_LAST  = 4'd10;

   localparam logic [4:0] TX_IDLE  = 5'd0;
   localparam logic [4:0] TX_START = 5'd1;
   localparam logic [4:0] TX_BIT0  = 5'd3;
   localparam logic [4:0] TX_BIT7  = 5'd17;
   localparam logic [4:0] TX_STOP  = 5'd19;
   localparam logic [4:0] TX_LAST  = 5'd24;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_byte;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
      logic       serial_out_level;
      logic       serial_out_valid;
      logic [7:0] port_value;
      logic       port_valid;
      logic [7:0] latched_address;
      logic       address_valid;
   } rsp_type;

endpackage

@@ design/serial_port_status_register_block_core.sv @@
// Top level of the serial port status register block: bus glue, status, port and serial unit.
// One request enters per cycle and gives exactly one response: the request
// is held in an input register, then one pass of update logic writes the device state and the
// response register together. Throughput is one request per cycle while the response side
// takes results; a stalled response holds the response register and the input register fills
// before the request side is stalled. Ticks drive the serial receiver and transmitter.
module serial_port_status_register_block_core
   import spsrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       in_valid_ff;
   req_type    in_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;
   rsp_type    out_in;
   logic       advance;

   logic [7:0] address_ff,   address_in;
   logic [7:0] status_ff,    status_in;
   logic [7:0] port_ff,      port_in;
   logic       rx_level_ff,  rx_level_in;
   logic [3:0] rx_step_ff,   rx_step_in;
   logic [7:0] rx_shift_ff,  rx_shift_in;
   logic [7:0] rx_buffer_ff, rx_buffer_in;
   logic [4:0] tx_step_ff,   tx_step_in;
   logic [7:0] tx_shift_ff,  tx_shift_in;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      address_in   = address_ff;
      status_in    = status_ff;
      port_in      = port_ff;
      rx_level_in  = rx_level_ff;
      rx_step_in   = rx_step_ff;
      rx_shift_in  = rx_shift_ff;
      rx_buffer_in = rx_buffer_ff;
      tx_step_in   = tx_step_ff;
      tx_shift_in  = tx_shift_ff;
      out_in       = '0;
      case (in_ff.opcode)
         OP_TICK: begin
            if (rx_step_ff == RX_START) begin
               rx_step_in = RX_FIRST;
            end else if (rx_step_ff >= RX_FIRST && rx_step_ff <= RX_BITS) begin
               rx_shift_in = (rx_shift_ff >> 1) | (rx_level_ff ? 8'h00 : BIT_MSB);
               rx_step_in  = rx_step_ff + 4'd1;
            end else if (rx_step_ff == RX_LAST) begin
               rx_buffer_in = rx_shift_ff;
               if ((status_ff & BIT_RX_READY) != 8'h00) begin
                  status_in = status_ff | BITS_OVERRUN;
               end else begin
                  status_in = status_ff & MASK_NO_OVERRUN;
               end
               status_in  = status_in | BIT_RX_READY;
               rx_step_in = RX_IDLE;
            end else begin
               rx_step_in = RX_IDLE;
            end
            if (tx_step_ff > TX_LAST) begin
               tx_step_in = TX_IDLE;
            end else if (tx_step_ff == TX_LAST) begin
               tx_step_in = TX_IDLE;
               status_in  = status_in | BITS_DONE;
            end else if (tx_step_ff != TX_IDLE) begin
               tx_step_in = tx_step_ff + 5'd1;
               if (tx_step_ff == TX_START) begin
                  out_in.serial_out_level = 1'b1;
                  out_in.serial_out_valid = 1'b1;
               end else if (tx_step_ff == TX_STOP) begin
                  out_in.serial_out_level = 1'b0;
                  out_in.serial_out_valid = 1'b1;
               end else if (tx_step_ff >= TX_BIT0 && tx_step_ff <= TX_BIT7 &&
                            tx_step_ff[0]) begin
                  out_in.serial_out_level = !tx_shift_ff[0];
                  out_in.serial_out_valid = 1'b1;
                  tx_shift_in = tx_shift_ff >> 1;
               end
            end
         end
         OP_LATCH: begin
            address_in             = in_ff.data_byte;
            out_in.latched_address = in_ff.data_byte;
            out_in.address_valid   = 1'b1;
         end
         OP_READ: begin
            if (address_ff == ADDR_SERIAL) begin
               out_in.read_data  = rx_buffer_ff;
               out_in.read_valid = 1'b1;
               status_in         = status_ff & ~BIT_RX_READY;
            end else if (address_ff == ADDR_STATUS) begin
               out_in.read_data  = status_ff;
               out_in.read_valid = 1'b1;
            end else if (address_ff == ADDR_PORT) begin
               out_in.read_data  = port_ff;
               out_in.read_valid = 1'b1;
            end
         end
         OP_WRITE: begin
            if (address_ff == ADDR_SERIAL) begin
               status_in   = (status_ff & MASK_NO_DONE) | BIT_TX_BUSY;
               tx_shift_in = in_ff.data_byte;
               tx_step_in  = TX_START;
            end else if (address_ff == ADDR_STATUS) begin
               status_in = in_ff.data_byte |
                           (((in_ff.data_byte & BIT_TX_BUSY) != 8'h00) ? BITS_DONE : 8'h00);
            end else if (address_ff == ADDR_PORT) begin
               port_in           = in_ff.data_byte;
               out_in.port_value = in_ff.data_byte;
               out_in.port_valid = 1'b1;
            end
         end
         OP_LEVEL: begin
            if (in_ff.line_level && !rx_level_ff && rx_step_ff == RX_IDLE) begin
               rx_step_in = RX_START;
            end
            rx_level_in = in_ff.line_level;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         address_ff   <= '0;
         status_ff    <= '0;
         port_ff      <= '0;
         rx_level_ff  <= 1'b0;
         rx_step_ff   <= RX_IDLE;
         rx_shift_ff  <= '0;
         rx_buffer_ff <= '0;
         tx_step_ff   <= TX_IDLE;
         tx_shift_ff  <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            address_ff   <= address_in;
            status_ff    <= status_in;
            port_ff      <= port_in;
            rx_level_ff  <= rx_level_in;
            rx_step_ff   <= rx_step_in;
            rx_shift_ff  <= rx_shift_in;
            rx_buffer_ff <= rx_buffer_in;
            tx_step_ff   <= tx_step_in;
            tx_shift_ff  <= tx_shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
      if (advance && in_valid_ff) begin
         out_ff <= out_in;
      end
   end

`include "serial_port_status_register_block_core_assert.svh"

   `SPSRB_ASSERT_NOW(a_rx_step_range, clock, reset, 1'b1, rx_step_ff <= RX_LAST)
   `SPSRB_ASSERT_NOW(a_tx_step_range, clock, reset, 1'b1, tx_step_ff <= TX_LAST)
   `SPSRB_ASSERT_NOW(a_one_kind, clock, reset, rsp_valid, $onehot0({rsp_data.read_valid, rsp_data.serial_out_valid, rsp_data.port_valid, rsp_data.address_valid}))
   `SPSRB_ASSERT_NEXT(a_input_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_ff))

endmodule
